@@ src/nfir_pkg.sv @@
// Shared constants, state encodings and types for the normalized FIR block.
// No dependencies; every other file in src/ uses this package.
package nfir_pkg;

  // Sizing
  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_TAPS     = 7;
  localparam int TAP_BITS     = 16;
  localparam int TCNT_BITS    = 3;
  localparam int CFG_IDX_BITS = $clog2(MAX_TAPS + 1);
  localparam int HALF_MAX     = MAX_TAPS / 2;
  localparam int SEEN_BITS    = $clog2(HALF_MAX + 1);
  localparam int OUT_IDX_BITS = SEEN_BITS;
  localparam int WIN_DEPTH    = 2 * HALF_MAX;
  localparam int WIN_IDX_BITS = $clog2(WIN_DEPTH);
  localparam int TAP_IDX_BITS = $clog2(MAX_TAPS);
  localparam int BUF_IDX_BITS = $clog2(3 * HALF_MAX + 1);
  localparam int GROW_BITS    = $clog2(MAX_TAPS + 1);
  localparam int PROD_BITS    = SAMPLE_BITS + TAP_BITS;
  localparam int ACC_BITS     = PROD_BITS + GROW_BITS;
  localparam int SUM_BITS     = TAP_BITS + GROW_BITS;
  localparam int NUM_BITS     = ACC_BITS + 1;
  localparam int DEN_BITS     = SUM_BITS + 1;
  localparam int Q_BITS       = SAMPLE_BITS;
  localparam int ITER_BITS    = $clog2(Q_BITS);

  // Register map
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_BASE  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_LAST  = CFG_IDX_BITS'(MAX_TAPS);

  // Reset values: single tap at unity gain
  localparam logic [TCNT_BITS-1:0]       TAP_COUNT_RST = TCNT_BITS'(1);
  localparam logic signed [TAP_BITS-1:0] TAP0_RST      = TAP_BITS'(16384);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_FLUSH,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT,
    S_FINISH
  } fir_state_e;

  typedef enum logic [2:0] {
    D_IDLE,
    D_PREP,
    D_CHECK,
    D_ITER,
    D_FIN
  } div_state_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          zero_gain;
    logic                          clipped;
  } div_res_t;

endpackage

@@ src/nfir_if.sv @@
// Valid/ready stream interfaces for the sample input and the filtered output.
// Depends on nfir_pkg for the sample width.
interface nfir_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [nfir_pkg::SAMPLE_BITS-1:0] sample;
  logic                                    final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface nfir_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [nfir_pkg::SAMPLE_BITS-1:0] filtered;
  logic                                    end_of_signal;
  logic                                    zero_gain;
  logic                                    clipped;

  modport source (output valid, output filtered, output end_of_signal,
                  output zero_gain, output clipped, input ready);
  modport sink   (input valid, input filtered, input end_of_signal,
                  input zero_gain, input clipped, output ready);
endinterface

@@ src/nfir_div.sv @@
// Sequential rounding divider: dot / sum, nearest with ties away from zero,
// saturated to the sample width. One quotient bit per cycle. Uses nfir_pkg.
module nfir_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [nfir_pkg::ACC_BITS-1:0]   dot_i,
  input  logic signed [nfir_pkg::SUM_BITS-1:0]   sum_i,
  output logic                                   done_o,
  output nfir_pkg::div_res_t                     res_o
);
  import nfir_pkg::*;

  localparam logic [Q_BITS-1:0] NEG_LIM = {1'b1, {(Q_BITS-1){1'b0}}};
  localparam logic [Q_BITS-1:0] POS_LIM = {1'b0, {(Q_BITS-1){1'b1}}};

  div_state_e            state_q, state_d;
  logic                  done_q;
  logic                  neg_q, zero_q, ovf_q;
  logic [ACC_BITS-1:0]   ad_q;
  logic [SUM_BITS-1:0]   as_q;
  logic [NUM_BITS-1:0]   num_q;
  logic [DEN_BITS-1:0]   d_q, rem_q;
  logic [Q_BITS-1:0]     nlo_q, q_q;
  logic [ITER_BITS-1:0]  cnt_q;
  div_res_t              res_q, res_c;

  logic                  ovf_c;
  logic [DEN_BITS:0]     trial;
  logic                  ge;

  assign ovf_c = NUM_BITS'(num_q[NUM_BITS-1:Q_BITS]) >= NUM_BITS'(d_q);
  assign trial = {rem_q, nlo_q[Q_BITS-1]};
  assign ge    = trial >= {1'b0, d_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE:  if (start_i) state_d = D_PREP;
      D_PREP:  state_d = D_CHECK;
      D_CHECK: state_d = (zero_q || ovf_c) ? D_FIN : D_ITER;
      D_ITER:  if (cnt_q == '0) state_d = D_FIN;
      D_FIN:   state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  // Zero-gain flag, sign fix-up and saturation of the unsigned quotient
  always_comb begin
    res_c.filtered  = '0;
    res_c.zero_gain = 1'b0;
    res_c.clipped   = 1'b0;
    if (zero_q) begin
      res_c.zero_gain = 1'b1;
    end else if (ovf_q) begin
      res_c.clipped  = 1'b1;
      res_c.filtered = neg_q ? $signed(NEG_LIM) : $signed(POS_LIM);
    end else if (q_q == '0) begin
      res_c.filtered = '0;
    end else if (neg_q) begin
      if (q_q > NEG_LIM) begin
        res_c.clipped  = 1'b1;
        res_c.filtered = $signed(NEG_LIM);
      end else begin
        res_c.filtered = $signed(Q_BITS'(0) - q_q);
      end
    end else begin
      if (q_q > POS_LIM) begin
        res_c.clipped  = 1'b1;
        res_c.filtered = $signed(POS_LIM);
      end else begin
        res_c.filtered = $signed(q_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == D_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          neg_q  <= dot_i[ACC_BITS-1] ^ sum_i[SUM_BITS-1];
          zero_q <= (sum_i == '0);
          ad_q   <= dot_i[ACC_BITS-1] ? ACC_BITS'(-dot_i) : ACC_BITS'(dot_i);
          as_q   <= sum_i[SUM_BITS-1] ? SUM_BITS'(-sum_i) : SUM_BITS'(sum_i);
        end
      end
      D_PREP: begin
        // numerator 2|dot| + |sum|, divisor 2|sum|
        num_q <= {ad_q, 1'b0} + NUM_BITS'(as_q);
        d_q   <= {as_q, 1'b0};
      end
      D_CHECK: begin
        ovf_q <= ovf_c;
        rem_q <= DEN_BITS'(num_q[NUM_BITS-1:Q_BITS]);
        nlo_q <= num_q[Q_BITS-1:0];
        q_q   <= '0;
        cnt_q <= ITER_BITS'(Q_BITS - 1);
      end
      D_ITER: begin
        rem_q <= ge ? DEN_BITS'(trial - {1'b0, d_q}) : DEN_BITS'(trial);
        q_q   <= {q_q[Q_BITS-2:0], ge};
        nlo_q <= {nlo_q[Q_BITS-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      D_FIN: res_q <= res_c;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == D_IDLE) else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held longer than one cycle");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.zero_gain && res_o.clipped))
    else $error("zero gain and clip raised together");

endmodule

@@ src/normalized_fir_edge_extend_unit.sv @@
// Normalized FIR with edge replication. One sample per input transfer; 0 to 4 results.
// Per result: a multiply-accumulate over the n taps (n = tap count), a flush and divider start,
// the bit-serial divider (one quotient bit per cycle), then a load of the output register,
// which waits while the output is held; a sample also takes an accept and a window update.
// A new sample is accepted only once every result of the previous one has been loaded.
// Reset (async, active low) clears control, the window and seen count; taps -> pass-through.
module normalized_fir_edge_extend_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [nfir_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [nfir_pkg::TAP_BITS-1:0]         cfg_data_i,
  nfir_in_if.sink                               in_i,
  nfir_out_if.source                            out_o
);
  import nfir_pkg::*;

  // Configuration registers
  logic [TCNT_BITS-1:0]          tap_count_q;
  logic signed [TAP_BITS-1:0]    taps_q [MAX_TAPS];

  // Signal state: window holds past samples, newest at index 0
  logic signed [SAMPLE_BITS-1:0] window_q [WIN_DEPTH];
  logic [SEEN_BITS-1:0]          seen_q;

  // Per-sample working registers
  fir_state_e                    state_q, state_d;
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic                          fin_q;
  logic [OUT_IDX_BITS-1:0]       k_q, k_end_q;
  logic [TAP_IDX_BITS-1:0]       j_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [ACC_BITS-1:0]    acc_q;
  logic signed [SUM_BITS-1:0]    sum_q;

  // Output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] filtered_q;
  logic                          eos_q, zero_q, clip_q;

  // Divider hookup
  logic                          div_start, div_done;
  div_res_t                      div_res;

  // Decoded controls
  logic                          accept, out_free, out_load, last_out, j_last;
  logic [TCNT_BITS-1:0]          n_eff;
  logic [OUT_IDX_BITS-1:0]       half;
  logic                          odd;
  logic                          seen_ge;
  logic                          has_out;
  logic [OUT_IDX_BITS-1:0]       k_first, k_end;
  logic [BUF_IDX_BITS-1:0]       buf_idx, two_h, win_off;
  logic signed [SAMPLE_BITS-1:0] sel_sample;
  logic signed [TAP_BITS-1:0]    tap_sel;

  assign n_eff = (32'(tap_count_q) > MAX_TAPS) ? TCNT_BITS'(MAX_TAPS) : tap_count_q;
  assign half  = OUT_IDX_BITS'(n_eff >> 1);
  assign odd   = n_eff[0];

  // Output plan for the arriving sample (odd tap counts only): one result once the window is primed,
  // or, on the final sample, every result still owed from the first pending one.
  assign seen_ge = seen_q >= half;
  assign has_out = odd && (in_i.final_sample || seen_ge);
  assign k_first = (in_i.final_sample && !seen_ge) ? OUT_IDX_BITS'(half - seen_q) : '0;
  assign k_end   = in_i.final_sample ? half : '0;

  // Extended segment: positions at or past 2h are the current sample,
  // earlier ones come from the window, oldest first.
  assign buf_idx    = BUF_IDX_BITS'(k_q) + BUF_IDX_BITS'(j_q);
  assign two_h      = BUF_IDX_BITS'({half, 1'b0});
  assign win_off    = two_h - BUF_IDX_BITS'(1) - buf_idx;
  assign sel_sample = (buf_idx >= two_h) ? cur_q : window_q[win_off[WIN_IDX_BITS-1:0]];
  assign tap_sel    = taps_q[j_q];
  assign j_last     = (j_q == TAP_IDX_BITS'(n_eff - 1'b1));

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign last_out = (k_q == k_end_q);

  nfir_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dot_i   (acc_q),
    .sum_i   (sum_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (accept) state_d = has_out ? S_MAC : S_FINISH;
      S_MAC:       if (j_last) state_d = S_FLUSH;
      S_FLUSH:     state_d = S_DIV_START;
      S_DIV_START: state_d = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_done) state_d = S_EMIT;
      S_EMIT:      if (out_free) state_d = last_out ? S_FINISH : S_MAC;
      S_FINISH:    state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE:      in_i.ready = 1'b1;
      S_DIV_START: div_start  = 1'b1;
      S_EMIT:      out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      tap_count_q <= TAP_COUNT_RST;
      for (int i = 0; i < MAX_TAPS; i++) begin
        taps_q[i] <= (i == 0) ? TAP0_RST : '0;
      end
      for (int i = 0; i < WIN_DEPTH; i++) begin
        window_q[i] <= '0;
      end
      seen_q      <= '0;
    end else begin
      state_q <= state_d;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TAP_COUNT) begin
          tap_count_q <= cfg_data_i[TCNT_BITS-1:0];
        end else if (cfg_idx_i >= CFG_TAP_BASE && cfg_idx_i <= CFG_TAP_LAST) begin
          taps_q[TAP_IDX_BITS'(cfg_idx_i - CFG_TAP_BASE)] <= $signed(cfg_data_i);
        end
      end

      if (accept) begin
        // first sample of a signal replicates the left edge
        if (seen_q == '0) begin
          for (int i = 0; i < WIN_DEPTH; i++) begin
            window_q[i] <= in_i.sample;
          end
        end
        if (in_i.final_sample) begin
          seen_q <= '0;
        end else if (32'(seen_q) < HALF_MAX) begin
          seen_q <= seen_q + 1'b1;
        end
      end else if (state_q == S_FINISH) begin
        // advance the window by one sample
        for (int i = WIN_DEPTH - 1; i > 0; i--) begin
          window_q[i] <= window_q[i-1];
        end
        window_q[0] <= cur_q;
      end
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q   <= in_i.sample;
      fin_q   <= in_i.final_sample;
      k_q     <= k_first;
      k_end_q <= k_end;
      j_q     <= '0;
    end

    if (state_q == S_MAC) begin
      prod_q <= PROD_BITS'(sel_sample) * PROD_BITS'(tap_sel);
      acc_q  <= (j_q == '0) ? '0 : acc_q + ACC_BITS'(prod_q);
      sum_q  <= ((j_q == '0) ? '0 : sum_q) + SUM_BITS'(tap_sel);
      j_q    <= j_last ? '0 : j_q + 1'b1;
    end

    if (state_q == S_FLUSH) begin
      acc_q <= acc_q + ACC_BITS'(prod_q);
    end

    if (out_load) begin
      filtered_q <= div_res.filtered;
      eos_q      <= fin_q && last_out;
      zero_q     <= div_res.zero_gain;
      clip_q     <= div_res.clipped;
      if (!last_out) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.filtered      = filtered_q;
  assign out_o.end_of_signal = eos_q;
  assign out_o.zero_gain     = zero_q;
  assign out_o.clipped       = clip_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE) else $error("sequencer did not leave idle after transfer");
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT) else $error("divider finished outside wait state");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (k_q <= k_end_q)) else $error("output index past the end");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.zero_gain && out_o.clipped))
    else $error("zero gain and clip on the same result");

endmodule
